### design/ppra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppra_pkg: shared constants for the paged process resize allocator
// sizes of the frame pool and page tables, field widths and status codes
// ----------------------------------------------------------------------------
package ppra_pkg;

  // page and pool geometry
  localparam int unsigned PAGE_SIZE  = 32;
  localparam int unsigned NUM_FRAMES = 256;
  localparam int unsigned MAX_PROCS  = 16;
  localparam int unsigned MAX_PAGES  = 64;

  // page size is a power of two, so byte to page math is a shift
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_SIZE);

  // fixed field widths
  localparam int unsigned PID_W    = 4;
  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PAGES_W  = 7;

  // derived widths
  localparam int unsigned FRAME_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned FCNT_W   = $clog2(NUM_FRAMES + 1);
  localparam int unsigned PROC_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned ADDR_W   = (MAX_PROCS * MAX_PAGES > 1) ?
                                     $clog2(MAX_PROCS * MAX_PAGES) : 1;
  localparam int unsigned CALC_W   = $clog2(MAX_PAGES * PAGE_SIZE + (1 << SIZE_W)
                                            + PAGE_SIZE) + 1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFRAMES = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CAPACITY = 2'd2;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EVAL    = 6'b000010,
    S_FREE_RD = 6'b000100,
    S_FREE_WR = 6'b001000,
    S_GROW    = 6'b010000,
    S_RESP    = 6'b100000
  } state_e;

endpackage

### design/paged_process_resize_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_process_resize_allocator_top: per-process page resize with a
// first-fit frame bitmap
// sequence: an accepted beat goes from EVAL to RESP when no page moves;
//   shrink passes FREE_RD then FREE_WR per freed page (page table read, then bitmap clear);
//   grow scans bitmap entries in turn from entry 0, up to NUM_FRAMES (256)
// flow: one request at a time, ready only while the sequencer idles;
//   a finished result waits in the output register while the next beat enters
// reset: bitmap, free count, page counts and sizes clear at once, no sweep;
//   page table contents stay undefined until written
// ----------------------------------------------------------------------------
module paged_process_resize_allocator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ppra_pkg::PID_W-1:0]      process_id_i,
  input  logic [ppra_pkg::SIZE_W-1:0]     new_size_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ppra_pkg::STATUS_W-1:0]   status_o,
  output logic [ppra_pkg::PAGES_W-1:0]    pages_held_o
);

  localparam int unsigned CW = ppra_pkg::CALC_W;

  // sequencer and per-request working registers
  ppra_pkg::state_e                    state_q, state_d;
  logic [ppra_pkg::PID_W-1:0]          pid_q;
  logic [ppra_pkg::SIZE_W-1:0]         req_q;
  logic [ppra_pkg::PAGES_W-1:0]        held_q, held_d;   // running page count
  logic [ppra_pkg::PAGES_W-1:0]        cnt_q, cnt_d;     // pages left to move
  logic [ppra_pkg::FRAME_W-1:0]        scan_q, scan_d;   // first-fit scan pointer
  logic [ppra_pkg::STATUS_W-1:0]       status_q, status_d;

  // allocator state
  logic [ppra_pkg::NUM_FRAMES-1:0]     frame_used_q;
  logic [ppra_pkg::FCNT_W-1:0]         free_cnt_q;
  logic [ppra_pkg::PAGES_W-1:0]        page_count_q [ppra_pkg::MAX_PROCS];
  logic [ppra_pkg::SIZE_W-1:0]         process_size_q [ppra_pkg::MAX_PROCS];

  // page table memory, registered read
  logic [ppra_pkg::FRAME_W-1:0]        page_mem [ppra_pkg::MAX_PROCS * ppra_pkg::MAX_PAGES];
  logic [ppra_pkg::FRAME_W-1:0]        rd_frame_q;
  logic [ppra_pkg::ADDR_W-1:0]         base_addr, rd_addr, wr_addr;
  logic                                mem_we;

  // output register
  logic                                out_valid_q;
  logic [ppra_pkg::STATUS_W-1:0]       out_status_q;
  logic [ppra_pkg::PAGES_W-1:0]        out_pages_q;

  // control strobes
  logic                                in_fire, out_load;
  logic                                frame_set, frame_clr;
  logic                                tbl_we;
  logic [ppra_pkg::PAGES_W-1:0]        tbl_cnt;

  // decision datapath for the current process
  logic [ppra_pkg::PROC_W-1:0]         pidx;
  logic                                pid_ok;
  logic [ppra_pkg::PAGES_W-1:0]        cur_held;
  logic [ppra_pkg::SIZE_W-1:0]         cur_size;
  logic [CW-1:0]                       bytes_held, req_w, drop_w, need_w;
  logic                                scan_free;

  assign in_ready_o   = (state_q == ppra_pkg::S_IDLE);
  assign in_fire      = in_valid_i & in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign pages_held_o = out_pages_q;

  assign pid_ok   = ({1'b0, pid_q} < (ppra_pkg::PID_W + 1)'(ppra_pkg::MAX_PROCS));
  assign pidx     = ppra_pkg::PROC_W'(pid_q);
  assign cur_held = page_count_q[pidx];
  assign cur_size = process_size_q[pidx];

  // bytes already backed by pages, and page deltas for shrink and grow
  assign bytes_held = CW'(cur_held) * CW'(ppra_pkg::PAGE_SIZE);
  assign req_w      = CW'(req_q);
  assign drop_w     = (bytes_held - req_w) >> ppra_pkg::PAGE_SHIFT;
  assign need_w     = (req_w - bytes_held + CW'(ppra_pkg::PAGE_SIZE - 1)) >>
                      ppra_pkg::PAGE_SHIFT;

  assign scan_free  = ~frame_used_q[scan_q];

  // page table addressing: process base plus page slot
  assign base_addr = ppra_pkg::ADDR_W'(pidx) * ppra_pkg::ADDR_W'(ppra_pkg::MAX_PAGES);
  assign rd_addr   = base_addr + ppra_pkg::ADDR_W'(held_q) - ppra_pkg::ADDR_W'(1);
  assign wr_addr   = base_addr + ppra_pkg::ADDR_W'(held_q);

  // sequencer
  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    cnt_d     = cnt_q;
    scan_d    = scan_q;
    status_d  = status_q;
    frame_set = 1'b0;
    frame_clr = 1'b0;
    mem_we    = 1'b0;
    tbl_we    = 1'b0;
    tbl_cnt   = cur_held;
    out_load  = 1'b0;
    case (state_q)
      ppra_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = ppra_pkg::S_EVAL;
        end
      end
      ppra_pkg::S_EVAL: begin
        status_d = ppra_pkg::ST_DONE;
        held_d   = cur_held;
        state_d  = ppra_pkg::S_RESP;
        if (!pid_ok) begin
          status_d = ppra_pkg::ST_CAPACITY;
        end else if (cur_size > req_q) begin
          // shrink: free whole pages beyond the new size from the table end
          if ((bytes_held > req_w) && (drop_w != '0)) begin
            cnt_d   = ppra_pkg::PAGES_W'(drop_w);
            state_d = ppra_pkg::S_FREE_RD;
          end else begin
            tbl_we = 1'b1;
          end
        end else if (cur_size < req_q) begin
          if (bytes_held < req_w) begin
            if ((CW'(cur_held) + need_w) > CW'(ppra_pkg::MAX_PAGES)) begin
              status_d = ppra_pkg::ST_CAPACITY;
            end else if (CW'(free_cnt_q) < need_w) begin
              status_d = ppra_pkg::ST_NOFRAMES;
            end else begin
              cnt_d   = ppra_pkg::PAGES_W'(need_w);
              scan_d  = '0;
              state_d = ppra_pkg::S_GROW;
            end
          end else begin
            // growth within pages already held
            tbl_we = 1'b1;
          end
        end
      end
      ppra_pkg::S_FREE_RD: begin
        // page table read of the last held page is in flight
        held_d  = held_q - ppra_pkg::PAGES_W'(1);
        state_d = ppra_pkg::S_FREE_WR;
      end
      ppra_pkg::S_FREE_WR: begin
        frame_clr = 1'b1;
        cnt_d     = cnt_q - ppra_pkg::PAGES_W'(1);
        if (cnt_q == ppra_pkg::PAGES_W'(1)) begin
          tbl_we  = 1'b1;
          tbl_cnt = held_q;
          state_d = ppra_pkg::S_RESP;
        end else begin
          state_d = ppra_pkg::S_FREE_RD;
        end
      end
      ppra_pkg::S_GROW: begin
        scan_d = scan_q + ppra_pkg::FRAME_W'(1);
        if (scan_free) begin
          frame_set = 1'b1;
          mem_we    = 1'b1;
          held_d    = held_q + ppra_pkg::PAGES_W'(1);
          cnt_d     = cnt_q - ppra_pkg::PAGES_W'(1);
          if (cnt_q == ppra_pkg::PAGES_W'(1)) begin
            tbl_we  = 1'b1;
            tbl_cnt = held_q + ppra_pkg::PAGES_W'(1);
            state_d = ppra_pkg::S_RESP;
          end
        end
      end
      ppra_pkg::S_RESP: begin
        // wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ppra_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ppra_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppra_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pid_q <= process_id_i;
      req_q <= new_size_i;
    end
    held_q   <= held_d;
    cnt_q    <= cnt_d;
    scan_q   <= scan_d;
    status_q <= status_d;
  end

  // frame bitmap and free frame count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_used_q <= '0;
      free_cnt_q   <= ppra_pkg::FCNT_W'(ppra_pkg::NUM_FRAMES);
    end else if (frame_set) begin
      frame_used_q[scan_q] <= 1'b1;
      free_cnt_q           <= free_cnt_q - ppra_pkg::FCNT_W'(1);
    end else if (frame_clr) begin
      frame_used_q[rd_frame_q] <= 1'b0;
      free_cnt_q               <= free_cnt_q + ppra_pkg::FCNT_W'(1);
    end
  end

  // per-process page count and recorded size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ppra_pkg::MAX_PROCS; i++) begin
        page_count_q[i]   <= '0;
        process_size_q[i] <= '0;
      end
    end else if (tbl_we) begin
      page_count_q[pidx]   <= tbl_cnt;
      process_size_q[pidx] <= req_q;
    end
  end

  // page table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      page_mem[wr_addr] <= scan_q;
    end
    rd_frame_q <= page_mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_pages_q  <= pid_ok ? cur_held : '0;
    end
  end

endmodule

### design/ppra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppra_checker: port-level checks for the resize allocator
// watches the handshakes and result fields, bound onto the top level
// ----------------------------------------------------------------------------
module ppra_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_o,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic [ppra_pkg::STATUS_W-1:0]   status_o,
  input  logic [ppra_pkg::PAGES_W-1:0]    pages_held_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(pages_held_o))
    else $error("result beat changed while stalled");

  // one request in flight: busy right after an accepted beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a second beat while busy");

  // only defined status codes come out
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ppra_pkg::ST_DONE) ||
      (status_o == ppra_pkg::ST_NOFRAMES) || (status_o == ppra_pkg::ST_CAPACITY))
    else $error("undefined status code");

  // page count never passes table capacity
  a_pages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, pages_held_o} <=
      (ppra_pkg::PAGES_W + 1)'(ppra_pkg::MAX_PAGES)))
    else $error("pages held exceeds page table capacity");

endmodule

bind paged_process_resize_allocator_top ppra_checker u_ppra_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .pages_held_o (pages_held_o)
);
